// File: rtl/cell_velocity_pressure_limiter_top_macros.svh
// assertion macros for the limiter rtl
`ifndef CELL_VELOCITY_PRESSURE_LIMITER_TOP_MACROS_SVH
`define CELL_VELOCITY_PRESSURE_LIMITER_TOP_MACROS_SVH
`ifndef SYNTH
// plain property on i_clk, off during reset
`define CLV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// overlapping implication on i_clk, off during reset
`define CLV_ASSERT_IMP(lbl, ante, cons, msg) \
    `CLV_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define CLV_ASSERT(lbl, prop, msg)
`define CLV_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/clv_pkg.sv
// shared widths, register indexes and item types of the limiter
package clv_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LIM_W      = DATA_WIDTH - 1;
    localparam int SUM_W      = 2 * DATA_WIDTH;
    localparam int ROOT_W     = DATA_WIDTH;
    localparam int KW         = FRAC_BITS + 1;
    localparam int NUM_W      = LIM_W + FRAC_BITS;
    localparam int PROD_W     = DATA_WIDTH + KW;
    localparam int TDATA_W    = ((4 * DATA_WIDTH + 7) / 8) * 8;
    localparam int TUSER_W    = 2;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VEL_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL    = 3'd4;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    // payload that travels beside the arithmetic
    typedef struct packed {
        t_word vx;
        t_word vy;
        t_word vz;
        t_word p;
        logic  pflag;
        logic  act;
    } t_cell;

    function automatic logic [DATA_WIDTH-1:0] magnitude(input t_word v);
        return v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
    endfunction
endpackage

// File: rtl/clv_sumsq.sv
// squared speed and limit compare, three stages
module clv_sumsq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  clv_pkg::t_cell                i_cell,
    input  logic                          i_vel_on,
    input  logic [clv_pkg::SUM_W-1:0]     i_lim_sq,
    output logic                          o_valid,
    output logic [clv_pkg::SUM_W-1:0]     o_sum,
    output clv_pkg::t_cell                o_cell
);
    import clv_pkg::*;

    logic             r_vld1, r_vld2, r_vld3;
    logic [SUM_W-1:0] r_sq [3];
    logic [SUM_W-1:0] r_sum2, r_sum3;
    t_cell            r_c1, r_c2, r_c3;
    t_cell            n_c3;
    logic [DATA_WIDTH-1:0] mag [3];

    assign mag[0] = magnitude(i_cell.vx);
    assign mag[1] = magnitude(i_cell.vy);
    assign mag[2] = magnitude(i_cell.vz);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // limit decision
    always_comb begin
        n_c3     = r_c2;
        n_c3.act = i_vel_on && (r_sum2 > i_lim_sq);
    end

    // squares, full-width sum, compare
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SUM_W'(mag[i]) * SUM_W'(mag[i]);
            end
            r_c1   <= i_cell;
            r_sum2 <= r_sq[0] + r_sq[1] + r_sq[2];
            r_c2   <= r_c1;
            r_sum3 <= r_sum2;
            r_c3   <= n_c3;
        end
    end

    assign o_valid = r_vld3;
    assign o_sum   = r_sum3;
    assign o_cell  = r_c3;
endmodule

// File: rtl/clv_isqrt.sv
// pipelined integer square root, one root bit per stage
`include "cell_velocity_pressure_limiter_top_macros.svh"
module clv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [clv_pkg::SUM_W-1:0]     i_sum,
    input  clv_pkg::t_cell                i_cell,
    output logic                          o_valid,
    output logic [clv_pkg::ROOT_W-1:0]    o_root,
    output clv_pkg::t_cell                o_cell
);
    import clv_pkg::*;

    localparam int MID = ROOT_W / 2;

    logic [ROOT_W:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_n    [ROOT_W];
    t_cell             r_c    [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [ROOT_W:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  n_in;
        logic              vld_in;
        t_cell             c_in;
        logic [ROOT_W+2:0] rem_t;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        logic              take;
        logic [ROOT_W:0]   n_rem;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = i_sum;
            assign vld_in  = i_valid;
            assign c_in    = i_cell;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign n_in    = r_n[g-1];
            assign vld_in  = r_vld[g-1];
            assign c_in    = r_c[g-1];
        end

        // try subtracting 4*root+1 from the shifted remainder
        assign rem_t = {rem_in, n_in[SUM_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = rem_t >= trial;
        assign diff  = rem_t - trial;
        assign n_rem = take ? diff[ROOT_W:0] : rem_t[ROOT_W:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= (root_in << 1) | ROOT_W'(take);
                r_n[g]    <= n_in << 2;
                r_c[g]    <= c_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_cell  = r_c[ROOT_W-1];

    `CLV_ASSERT_IMP(a_rem_last, r_vld[ROOT_W-1], ({1'b0, r_rem[ROOT_W-1]} <= {r_root[ROOT_W-1], 2'b00}), "root remainder too large at last stage")
    `CLV_ASSERT_IMP(a_rem_mid, r_vld[MID], ({1'b0, r_rem[MID]} <= {r_root[MID], 2'b00}), "root remainder too large at middle stage")
    `CLV_ASSERT_IMP(a_root_grow, $past(i_en) && r_vld[1], ((r_root[1] >> 1) == $past(r_root[0])), "root did not grow by one bit")
endmodule

// File: rtl/clv_div.sv
// pipelined restoring divider for the scale factor, one quotient bit per stage
module clv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [clv_pkg::ROOT_W-1:0]    i_root,
    input  logic [clv_pkg::LIM_W-1:0]     i_limit,
    input  clv_pkg::t_cell                i_cell,
    output logic                          o_valid,
    output logic [clv_pkg::KW-1:0]        o_quot,
    output clv_pkg::t_cell                o_cell
);
    import clv_pkg::*;

    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] r_rem [KW];
    logic [ROOT_W-1:0] r_dvs [KW];
    logic [KW-1:0]     r_lo  [KW];
    logic [KW-1:0]     r_q   [KW];
    t_cell             r_c   [KW];
    logic [KW-1:0]     r_vld;

    // numerator is the limit shifted up by the fraction bits
    assign num = NUM_W'(i_limit) << FRAC_BITS;

    for (genvar g = 0; g < KW; g++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [ROOT_W-1:0] dvs_in;
        logic [KW-1:0]     lo_in;
        logic [KW-1:0]     q_in;
        logic              vld_in;
        t_cell             c_in;
        logic [ROOT_W:0]   rem_t;
        logic [ROOT_W:0]   diff;
        logic              take;

        if (g == 0) begin : g_first
            assign rem_in = ROOT_W'(num >> KW);
            assign dvs_in = i_root;
            assign lo_in  = num[KW-1:0];
            assign q_in   = '0;
            assign vld_in = i_valid;
            assign c_in   = i_cell;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign dvs_in = r_dvs[g-1];
            assign lo_in  = r_lo[g-1];
            assign q_in   = r_q[g-1];
            assign vld_in = r_vld[g-1];
            assign c_in   = r_c[g-1];
        end

        // bring down one numerator bit and try the subtract
        assign rem_t = {rem_in, lo_in[KW-1]};
        assign take  = rem_t >= {1'b0, dvs_in};
        assign diff  = rem_t - {1'b0, dvs_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= take ? diff[ROOT_W-1:0] : rem_t[ROOT_W-1:0];
                r_dvs[g] <= dvs_in;
                r_lo[g]  <= lo_in << 1;
                r_q[g]   <= (q_in << 1) | KW'(take);
                r_c[g]   <= c_in;
            end
        end
    end

    assign o_valid = r_vld[KW-1];
    assign o_quot  = r_q[KW-1];
    assign o_cell  = r_c[KW-1];
endmodule

// File: rtl/clv_scale.sv
// component scaling and final select, two stages ending in the output register
module clv_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [clv_pkg::KW-1:0]        i_quot,
    input  clv_pkg::t_cell                i_cell,
    output logic                          o_valid,
    output clv_pkg::t_cell                o_res
);
    import clv_pkg::*;

    logic              r_vld_a, r_vld_b;
    logic [PROD_W-1:0] r_prod [3];
    t_cell             r_c_a, r_res;
    t_cell             n_res;
    t_word             comp [3];
    t_word             scaled [3];

    assign comp[0] = i_cell.vx;
    assign comp[1] = i_cell.vy;
    assign comp[2] = i_cell.vz;

    // truncate toward zero: scale the magnitude, then restore the sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scaled[i] = 0;
        end
        scaled[0] = r_c_a.vx[DATA_WIDTH-1] ? -t_word'(r_prod[0][FRAC_BITS +: DATA_WIDTH])
                                           :  t_word'(r_prod[0][FRAC_BITS +: DATA_WIDTH]);
        scaled[1] = r_c_a.vy[DATA_WIDTH-1] ? -t_word'(r_prod[1][FRAC_BITS +: DATA_WIDTH])
                                           :  t_word'(r_prod[1][FRAC_BITS +: DATA_WIDTH]);
        scaled[2] = r_c_a.vz[DATA_WIDTH-1] ? -t_word'(r_prod[2][FRAC_BITS +: DATA_WIDTH])
                                           :  t_word'(r_prod[2][FRAC_BITS +: DATA_WIDTH]);
        n_res = r_c_a;
        if (r_c_a.act) begin
            n_res.vx = scaled[0];
            n_res.vy = scaled[1];
            n_res.vz = scaled[2];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    // products, then output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= PROD_W'(magnitude(comp[i])) * PROD_W'(i_quot);
            end
            r_c_a <= i_cell;
            r_res <= n_res;
        end
    end

    assign o_valid = r_vld_b;
    assign o_res   = r_res;
endmodule

// File: rtl/cell_velocity_pressure_limiter_top.sv
// top level of the cell velocity and pressure limiter
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    vel x, y, z, pressure
//  m_axis    out        m_axis_tvalid/m_axis_tready    vel x, y, z, pressure + 2 flags
//  cfg       in         i_cfg_valid/o_cfg_ready        register index, write data
//
// one item per cycle while m_axis does not stall; pipeline: input register, 3 squaring stages,
// 32 root stages (one root bit each), 17 divider stages, 2 scaling stages
// the root pipeline is the longest section, the throughput is one item a cycle unless m_axis stalls
// synchronous active-low reset clears the valid bits and loads register defaults
// a stall at m_axis freezes the whole pipeline; s_axis_tready drops in the same cycle
module cell_velocity_pressure_limiter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // vel_x_in, vel_y_in, vel_z_in, pressure_in from bit 0 up
    input  logic [clv_pkg::TDATA_W-1:0]       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // vel_x_out, vel_y_out, vel_z_out, pressure_out from bit 0 up
    output logic [clv_pkg::TDATA_W-1:0]       m_axis_tdata,
    // velocity_limited, pressure_clamped from bit 0 up
    output logic [clv_pkg::TUSER_W-1:0]       m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [clv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clv_pkg::DATA_WIDTH-1:0]    i_cfg_data
);
    import clv_pkg::*;

    logic             r_vel_on, r_pres_on;
    logic [LIM_W-1:0] r_speed;
    t_word            r_floor, r_ceil;
    logic [SUM_W-1:0] r_lim_sq;

    logic  en;
    logic  r_vld0;
    t_cell r_c0, n_c0;
    t_word in_p, p_lo, p_hi;

    logic             sq_vld, rt_vld, dv_vld, out_vld;
    logic [SUM_W-1:0] sq_sum;
    logic [ROOT_W-1:0] rt_root;
    logic [KW-1:0]    dv_quot;
    t_cell            sq_c, rt_c, dv_c, out_res;

    // pipeline advances unless the output register holds an untaken item
    assign en            = !out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_on  <= 1'b0;
            r_pres_on <= 1'b0;
            r_speed   <= '1;
            r_floor   <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            r_ceil    <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VEL_ON:  r_vel_on  <= i_cfg_data[0];
                REG_PRES_ON: r_pres_on <= i_cfg_data[0];
                REG_SPEED:   r_speed   <= i_cfg_data[LIM_W-1:0];
                REG_FLOOR:   r_floor   <= t_word'(i_cfg_data);
                REG_CEIL:    r_ceil    <= t_word'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // squared limit, refreshed from the speed register
    always_ff @(posedge i_clk) begin
        r_lim_sq <= SUM_W'(r_speed) * SUM_W'(r_speed);
    end

    // unpack and clamp pressure, floor first so the ceiling wins
    assign in_p = t_word'(s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]);
    assign p_lo = (in_p < r_floor) ? r_floor : in_p;
    assign p_hi = (p_lo > r_ceil) ? r_ceil : p_lo;

    always_comb begin
        n_c0.vx    = t_word'(s_axis_tdata[0 +: DATA_WIDTH]);
        n_c0.vy    = t_word'(s_axis_tdata[DATA_WIDTH +: DATA_WIDTH]);
        n_c0.vz    = t_word'(s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
        n_c0.p     = r_pres_on ? p_hi : in_p;
        n_c0.pflag = r_pres_on && (p_hi != in_p);
        n_c0.act   = 1'b0;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (en) begin
            r_vld0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0 <= n_c0;
        end
    end

    clv_sumsq u_sumsq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_vld0),
        .i_cell   (r_c0),
        .i_vel_on (r_vel_on),
        .i_lim_sq (r_lim_sq),
        .o_valid  (sq_vld),
        .o_sum    (sq_sum),
        .o_cell   (sq_c)
    );

    clv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_sum   (sq_sum),
        .i_cell  (sq_c),
        .o_valid (rt_vld),
        .o_root  (rt_root),
        .o_cell  (rt_c)
    );

    clv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_vld),
        .i_root  (rt_root),
        .i_limit (r_speed),
        .i_cell  (rt_c),
        .o_valid (dv_vld),
        .o_quot  (dv_quot),
        .o_cell  (dv_c)
    );

    clv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_vld),
        .i_quot  (dv_quot),
        .i_cell  (dv_c),
        .o_valid (out_vld),
        .o_res   (out_res)
    );

    // output packing
    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = TDATA_W'({out_res.p, out_res.vz, out_res.vy, out_res.vx});
    assign m_axis_tuser  = {out_res.pflag, out_res.act};
endmodule

// File: sim/tb_top.sv
// testbench for the cell velocity and pressure limiter
`timescale 1ns / 100ps

module tb_top;
    import clv_pkg::*;

    // register index past the end of the list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [31:0] vx, vy, vz, p;
        logic        vlim, pclamp;
    } t_cell_out;

    // limit settings mirrored from the register writes
    bit          vel_on;
    bit          pres_on;
    logic [30:0] speed_lim;
    logic signed [31:0] p_floor, p_ceil;

    // integer square root of a 64 bit value, bit by bit
    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // magnitude times scale, truncated toward zero, sign restored
    function automatic logic [31:0] shrink(logic signed [31:0] v, logic [63:0] k);
        logic [63:0] m, q;
        m = v[31] ? 64'(-64'(v)) : 64'(v);
        q = (m * k) >> FRAC_BITS;
        return v[31] ? 32'(-q) : 32'(q);
    endfunction

    function automatic t_cell_out limit_cell(logic signed [31:0] vx, logic signed [31:0] vy,
                                             logic signed [31:0] vz, logic signed [31:0] p);
        t_cell_out o;
        logic [63:0] ax, ay, az, s, r, k;
        logic signed [31:0] po;
        o.vx = vx; o.vy = vy; o.vz = vz; o.vlim = 0; o.pclamp = 0;
        if (vel_on) begin
            ax = vx[31] ? 64'(-64'(vx)) : 64'(vx);
            ay = vy[31] ? 64'(-64'(vy)) : 64'(vy);
            az = vz[31] ? 64'(-64'(vz)) : 64'(vz);
            s = ax * ax + ay * ay + az * az;
            if (s > 64'(speed_lim) * 64'(speed_lim)) begin
                r = root_floor(s);
                k = (r != 0) ? (64'(speed_lim) << FRAC_BITS) / r : 0;
                o.vx = shrink(vx, k);
                o.vy = shrink(vy, k);
                o.vz = shrink(vz, k);
                o.vlim = 1;
            end
        end
        po = p;
        if (pres_on) begin
            if (po < p_floor) po = p_floor;
            if (po > p_ceil) po = p_ceil;
            o.pclamp = (po != p);
        end
        o.p = po;
        return o;
    endfunction

    // queue of expected cells, checked in order
    class cell_scoreboard;
        t_cell_out pending[$];
        int errors;
        int checked;

        function void note_cell(t_cell_out e);
            pending.push_back(e);
        endfunction

        function void check_cell(t_cell_out a);
            t_cell_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected cell %h %h %h %h %b%b", $time,
                         a.vx, a.vy, a.vz, a.p, a.vlim, a.pclamp);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if ({e.vx, e.vy, e.vz, e.p, e.vlim, e.pclamp} !=
                {a.vx, a.vy, a.vz, a.p, a.vlim, a.pclamp}) begin
                $display("%0t: mismatch exp %h %h %h %h v%b p%b got %h %h %h %h v%b p%b",
                         $time, e.vx, e.vy, e.vz, e.p, e.vlim, e.pclamp,
                         a.vx, a.vy, a.vz, a.p, a.vlim, a.pclamp);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_WIDTH-1:0] i_cfg_data;

    cell_scoreboard cells = new();
    int send_idle_pct, stall_pct;
    int n_sent;

    cell_velocity_pressure_limiter_top DUT (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: random stall, check each accepted cell
    always @(posedge i_clk) begin
        t_cell_out a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a.vx = m_axis_tdata[31:0];
            a.vy = m_axis_tdata[63:32];
            a.vz = m_axis_tdata[95:64];
            a.p  = m_axis_tdata[127:96];
            a.vlim = m_axis_tuser[0];
            a.pclamp = m_axis_tuser[1];
            cells.check_cell(a);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_VEL_ON:  vel_on = val[0];
            REG_PRES_ON: pres_on = val[0];
            REG_SPEED:   speed_lim = val[30:0];
            REG_FLOOR:   p_floor = val;
            REG_CEIL:    p_ceil = val;
            default: ;
        endcase
    endtask

    // one cell; tvalid stays high across back-to-back items
    task automatic send_cell(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {p, vz, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        cells.note_cell(limit_cell(vx, vy, vz, p));
        n_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (cells.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // random word, biased toward extremes and small magnitudes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(131072)) - 65536);
            3: return 32'($signed($urandom_range(2097152)) - 1048576);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_cells(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                case ((i / 50) % 5)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 56; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 56; end
                    3: begin send_idle_pct = 15; stall_pct = 15; end
                    default: begin send_idle_pct = 0; stall_pct = 0; end
                endcase
            end
            send_cell(rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    initial begin
        logic [31:0] lo, hi;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        vel_on = 0; pres_on = 0;
        speed_lim = 31'h7fff_ffff;
        p_floor = 32'sh8000_0000;
        p_ceil = 32'sh7fff_ffff;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset defaults: everything passes through
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        // limits on, moderate range
        write_reg(REG_VEL_ON, 1);
        write_reg(REG_PRES_ON, 1);
        write_reg(REG_SPEED, 32'h0001_0000);
        write_reg(REG_FLOOR, 32'hffff_0000);
        write_reg(REG_CEIL, 32'h0002_0000);
        send_cell(32'h0003_0000, 32'h0004_0000, 0, 32'h0005_0000);
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cell(32'h7fff_ffff, 32'h8000_0001, 32'h0000_0001, 32'h7fff_ffff);
        send_cell(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'hffff_0000);
        send_cell(32'h0001_0000, 0, 0, 32'h0001_0000);
        send_cell(0, 0, 0, 0);
        // pause until everything has come out
        drain();

        // zero speed limit; floor above ceiling
        write_reg(REG_SPEED, 0);
        write_reg(REG_FLOOR, 32'h0001_0000);
        write_reg(REG_CEIL, 32'hffff_0000);
        send_cell(0, 0, 0, 0);
        send_cell(1, 0, 0, 32'h0000_8000);
        send_cell(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        drain();
        // index beyond the list is ignored
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_cell(32'h0010_0000, 32'hfff0_0000, 5, 32'h7fff_ffff);
        drain();

        random_cells(300);
        drain();

        // extreme limits, clamping off
        write_reg(REG_SPEED, 32'h7fff_ffff);
        write_reg(REG_PRES_ON, 0);
        write_reg(REG_FLOOR, 32'h8000_0000);
        write_reg(REG_CEIL, 32'h7fff_ffff);
        random_cells(200);
        drain();

        // random settings per phase
        for (int ph = 0; ph < 6; ph++) begin
            lo = rand_word();
            hi = rand_word();
            write_reg(REG_VEL_ON, 32'(ph != 5));
            write_reg(REG_PRES_ON, 32'(ph != 4));
            write_reg(REG_SPEED, (ph % 2) ? $urandom_range(32'h0010_0000) : $urandom());
            write_reg(REG_FLOOR, ($signed(lo) < $signed(hi)) ? lo : hi);
            write_reg(REG_CEIL, ($signed(lo) < $signed(hi)) ? hi : lo);
            random_cells(100);
            drain();
        end

        $display("covered %0d cells (%0d checked) over limit and clamp settings,",
                 n_sent, cells.checked);
        $display("including zero limit, inverted range and mixed handshake gaps");
        if (cells.errors == 0 && cells.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/clv_pkg.sv
rtl/clv_sumsq.sv
rtl/clv_isqrt.sv
rtl/clv_div.sv
rtl/clv_scale.sv
rtl/cell_velocity_pressure_limiter_top.sv
sim/tb_top.sv
